FILE: sv/srtf_pkg.sv
// shared types and constants for the srtf schedule simulator
// no dependencies; used by srtf_job_store and srtf_schedule_simulator_unit
package srtf_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int TIME_W       = 16;
    localparam int SIM_W        = 21;
    localparam int IDX_OUT_W    = 4;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
    } t_in;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] job_index;
        logic [SIM_W-1:0]     finish_time;
        logic [SIM_W-1:0]     turnaround;
        logic [SIM_W-1:0]     waiting;
        logic                 last_result;
    } t_out;

    // write request into the job table
    typedef struct packed {
        logic load;     // write arrival, burst and remaining
        logic rem_only; // write remaining only
    } t_wr_ctl;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

endpackage

FILE: sv/srtf_job_store.sv
// job table: arrival, burst and remaining memories, one write and one read port
// read data registered; depends on srtf_pkg
module srtf_job_store #(
    parameter int DEPTH = srtf_pkg::MAX_JOBS_DEF,
    parameter int AW    = 4
) (
    input  logic                          i_clk,
    input  srtf_pkg::t_wr_ctl             i_wr_ctl,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [srtf_pkg::TIME_W-1:0]   i_wr_arr,
    input  logic [srtf_pkg::TIME_W-1:0]   i_wr_bur,
    input  logic [srtf_pkg::TIME_W-1:0]   i_wr_rem,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [srtf_pkg::TIME_W-1:0]   o_rd_arr,
    output logic [srtf_pkg::TIME_W-1:0]   o_rd_bur,
    output logic [srtf_pkg::TIME_W-1:0]   o_rd_rem
);

    logic [srtf_pkg::TIME_W-1:0] mem_arr [DEPTH];
    logic [srtf_pkg::TIME_W-1:0] mem_bur [DEPTH];
    logic [srtf_pkg::TIME_W-1:0] mem_rem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.load) begin
            mem_arr[i_wr_addr] <= i_wr_arr;
            mem_bur[i_wr_addr] <= i_wr_bur;
        end
        if (i_wr_ctl.load || i_wr_ctl.rem_only) begin
            mem_rem[i_wr_addr] <= i_wr_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_arr <= mem_arr[i_rd_addr];
        o_rd_bur <= mem_bur[i_rd_addr];
        o_rd_rem <= mem_rem[i_rd_addr];
    end

endmodule

FILE: sv/srtf_schedule_simulator_unit.sv
// top level of the shortest-remaining-time-first schedule simulator
// depends on srtf_pkg and srtf_job_store
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+-------------------------------------
//  command  | i_item (t_in)            | transaction when start & !busy
//  result   | o_result (t_out)         | o_valid for one cycle, always taken
//
// a load transaction can follow every cycle.
// a run works event by event: each event is one pass over the table of n jobs
// (one memory read per cycle) followed by an update step,
// plus an emit step when a job finishes; a run has at most 2n events.
// reset is synchronous and clears control state only, the table is not cleared.
// busy stays high for the whole run; the receiver cannot stall results.
module srtf_schedule_simulator_unit #(
    parameter int MAX_JOBS = srtf_pkg::MAX_JOBS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  srtf_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_valid,
    output srtf_pkg::t_out o_result
);

    localparam int TABLE_CAP = (MAX_JOBS < srtf_pkg::RESULT_LIMIT) ?
                               MAX_JOBS : srtf_pkg::RESULT_LIMIT;
    localparam int IW = (TABLE_CAP > 1) ? $clog2(TABLE_CAP) : 1;
    localparam int CW = $clog2(TABLE_CAP + 1);
    localparam int TW = srtf_pkg::TIME_W;
    localparam int SW = srtf_pkg::SIM_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_t, n_t;
    logic [SW-1:0] r_fin, n_fin;

    logic          r_found, n_found;
    logic [TW-1:0] r_best_rem, n_best_rem;
    logic [TW-1:0] r_best_arr, n_best_arr;
    logic [TW-1:0] r_best_bur, n_best_bur;
    logic [IW-1:0] r_best_idx, n_best_idx;
    logic          r_has_next, n_has_next;
    logic [TW-1:0] r_next_arr, n_next_arr;

    logic           n_valid;
    srtf_pkg::t_out n_result;

    srtf_pkg::t_wr_ctl wr_ctl;
    logic [IW-1:0]     wr_addr;
    logic [TW-1:0]     wr_rem;
    logic [IW-1:0]     rd_addr;
    logic [TW-1:0]     rd_arr, rd_bur, rd_rem;

    logic          accept;
    logic          data_ok, elig, take, later;
    logic [SW-1:0] gap, fin_sum, tat, wt;
    logic          finishes;

    srtf_job_store #(
        .DEPTH (TABLE_CAP),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_ctl  (wr_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_arr  (i_item.arrival_time),
        .i_wr_bur  (i_item.burst_length),
        .i_wr_rem  (wr_rem),
        .i_rd_addr (rd_addr),
        .o_rd_arr  (rd_arr),
        .o_rd_bur  (rd_bur),
        .o_rd_rem  (rd_rem)
    );

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign rd_addr = r_cnt[IW-1:0];

    // data of entry r_cnt - 1 is on the read port
    assign data_ok = (r_state == S_SCAN) && (r_cnt != '0);
    assign elig    = (rd_rem != '0) && ({{(SW-TW){1'b0}}, rd_arr} <= r_t);
    assign take    = data_ok && elig && (!r_found || (rd_rem < r_best_rem));
    assign later   = data_ok && (rd_rem != '0) && ({{(SW-TW){1'b0}}, rd_arr} > r_t) &&
                     (!r_has_next || (rd_arr < r_next_arr));

    assign gap      = {{(SW-TW){1'b0}}, r_next_arr} - r_t;
    assign fin_sum  = r_t + {{(SW-TW){1'b0}}, r_best_rem};
    assign finishes = !r_has_next || ({{(SW-TW){1'b0}}, r_best_rem} <= gap);

    assign tat = r_fin - {{(SW-TW){1'b0}}, r_best_arr};
    assign wt  = (tat > {{(SW-TW){1'b0}}, r_best_bur}) ?
                 (tat - {{(SW-TW){1'b0}}, r_best_bur}) : '0;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_done     = r_done;
        n_cnt      = r_cnt;
        n_t        = r_t;
        n_fin      = r_fin;
        n_found    = r_found;
        n_best_rem = r_best_rem;
        n_best_arr = r_best_arr;
        n_best_bur = r_best_bur;
        n_best_idx = r_best_idx;
        n_has_next = r_has_next;
        n_next_arr = r_next_arr;
        n_valid    = 1'b0;
        n_result   = o_result;
        wr_ctl     = '0;
        wr_addr    = r_best_idx;
        wr_rem     = i_item.burst_length;

        case (r_state)
            S_IDLE: begin
                wr_addr = r_count[IW-1:0];
                if (accept && (i_item.mode == srtf_pkg::MODE_LOAD)) begin
                    if ((i_item.burst_length != '0) && (r_count < CW'(TABLE_CAP))) begin
                        wr_ctl.load = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                end else if (accept && (r_count != '0)) begin
                    n_state    = S_SCAN;
                    n_t        = '0;
                    n_done     = '0;
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    n_has_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (take) begin
                    n_found    = 1'b1;
                    n_best_rem = rd_rem;
                    n_best_arr = rd_arr;
                    n_best_bur = rd_bur;
                    n_best_idx = IW'(r_cnt - 1'b1);
                end
                if (later) begin
                    n_has_next = 1'b1;
                    n_next_arr = rd_arr;
                end
                if (r_cnt == r_count) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPDATE: begin
                n_cnt      = '0;
                n_found    = 1'b0;
                n_has_next = 1'b0;
                if (r_found && finishes) begin
                    wr_ctl.rem_only = 1'b1;
                    wr_rem          = '0;
                    n_fin           = fin_sum;
                    n_t             = fin_sum;
                    n_done          = r_done + 1'b1;
                    n_state         = S_EMIT;
                end else if (r_found) begin
                    // preempt check at the next arrival
                    wr_ctl.rem_only = 1'b1;
                    wr_rem          = r_best_rem - gap[TW-1:0];
                    n_t             = {{(SW-TW){1'b0}}, r_next_arr};
                    n_state         = S_SCAN;
                end else begin
                    // idle ticks up to the next arrival
                    n_t     = {{(SW-TW){1'b0}}, r_next_arr};
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                n_valid              = 1'b1;
                n_result.job_index   = srtf_pkg::IDX_OUT_W'(r_best_idx);
                n_result.finish_time = r_fin;
                n_result.turnaround  = tat;
                n_result.waiting     = wt;
                n_result.last_result = (r_done == r_count);
                n_cnt                = '0;
                n_found              = 1'b0;
                n_has_next           = 1'b0;
                if (r_done == r_count) begin
                    n_count = '0;
                    n_done  = '0;
                    n_t     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_done     <= '0;
            r_cnt      <= '0;
            r_t        <= '0;
            r_found    <= 1'b0;
            r_has_next <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_done     <= n_done;
            r_cnt      <= n_cnt;
            r_t        <= n_t;
            r_found    <= n_found;
            r_has_next <= n_has_next;
            o_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin      <= n_fin;
        r_best_rem <= n_best_rem;
        r_best_arr <= n_best_arr;
        r_best_bur <= n_best_bur;
        r_best_idx <= n_best_idx;
        r_next_arr <= n_next_arr;
        o_result   <= n_result;
    end

endmodule

FILE: sim/srtf_schedule_simulator_unit_test.sv
`timescale 1ns / 1ps
// testbench for srtf_schedule_simulator_unit: directed table then random job sets
// depends on srtf_pkg and the unit; completions are checked against a local scheduler
module srtf_schedule_simulator_unit_test;

    localparam int TW             = srtf_pkg::TIME_W;
    localparam int SW             = srtf_pkg::SIM_W;
    localparam int XW             = srtf_pkg::IDX_OUT_W;
    localparam int TABLE_CAP      = (srtf_pkg::MAX_JOBS_DEF < srtf_pkg::RESULT_LIMIT) ?
                                    srtf_pkg::MAX_JOBS_DEF : srtf_pkg::RESULT_LIMIT;
    localparam int ITEMS_TARGET   = 260;
    localparam int QUIET_TAIL     = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 50;
    localparam srtf_pkg::t_out NO_CHECK = '0;

    typedef struct packed {
        srtf_pkg::t_in  item;
        logic           typed;
        srtf_pkg::t_out want;
    } t_stim_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    srtf_pkg::t_in  i_item;
    logic           busy;
    logic           o_valid;
    srtf_pkg::t_out o_result;

    srtf_schedule_simulator_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // scheduler state kept by the testbench
    logic [TW-1:0] job_arrival [TABLE_CAP];
    logic [TW-1:0] job_burst [TABLE_CAP];
    int unsigned   job_count;

    srtf_pkg::t_out predicted[$];
    srtf_pkg::t_out expected_completions[$];
    t_stim_row      directed_rows[$];
    srtf_pkg::t_out oldest;

    int  mismatches;
    int  items_counted;
    int  runs_sent;
    int  completions_checked;
    int  quiet_cycles;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // nonzero loads fill free slots; a run predicts every completion, empties the table
    function automatic bit predict_item(input srtf_pkg::t_in item);
        logic [TW-1:0] left [TABLE_CAP];
        int unsigned now;
        int unsigned next_arrival;
        int unsigned slice;
        int unsigned done;
        int unsigned tat;
        int unsigned wt;
        int pick;
        srtf_pkg::t_out c;
        predicted.delete();
        if (item.mode == srtf_pkg::MODE_LOAD) begin
            if (item.burst_length == 0 || job_count >= TABLE_CAP) return 1'b0;
            job_arrival[job_count] = item.arrival_time;
            job_burst[job_count]   = item.burst_length;
            job_count++;
            return 1'b1;
        end
        for (int k = 0; k < TABLE_CAP; k++) left[k] = job_burst[k];
        now  = 0;
        done = 0;
        while (done < job_count) begin
            pick = -1;
            next_arrival = 32'hFFFF_FFFF;
            for (int k = 0; k < job_count; k++) begin
                if (job_arrival[k] <= now) begin
                    if (left[k] != 0 && (pick < 0 || left[k] < left[pick])) pick = k;
                end else if (job_arrival[k] < next_arrival) begin
                    next_arrival = job_arrival[k];
                end
            end
            if (pick < 0) begin
                now = next_arrival;
            end else begin
                // the chosen job keeps the cpu until it finishes or someone arrives
                slice = left[pick];
                if (next_arrival - now < slice) slice = next_arrival - now;
                left[pick] = left[pick] - slice[TW-1:0];
                now += slice;
                if (left[pick] == 0) begin
                    done++;
                    tat = now - job_arrival[pick];
                    wt  = (tat > job_burst[pick]) ? tat - job_burst[pick] : 0;
                    c.job_index   = pick[XW-1:0];
                    c.finish_time = now[SW-1:0];
                    c.turnaround  = tat[SW-1:0];
                    c.waiting     = wt[SW-1:0];
                    c.last_result = (done == job_count);
                    predicted.push_back(c);
                end
            end
        end
        job_count = 0;
        return 1'b1;
    endfunction

    function automatic srtf_pkg::t_out completion(input int idx, input int fin, input int tat,
                                                  input int wt, input bit last);
        srtf_pkg::t_out c;
        c.job_index   = XW'(idx);
        c.finish_time = SW'(fin);
        c.turnaround  = SW'(tat);
        c.waiting     = SW'(wt);
        c.last_result = last;
        return c;
    endfunction

    function automatic void add_row(input logic mode, input int arr, input int bur,
                                    input logic typed, input srtf_pkg::t_out want);
        t_stim_row r;
        r.item.mode         = mode;
        r.item.arrival_time = TW'(arr);
        r.item.burst_length = TW'(bur);
        r.typed             = typed;
        r.want              = want;
        directed_rows.push_back(r);
    endfunction

    function automatic void build_directed();
        // run with nothing loaded, fields set but ignored
        add_row(srtf_pkg::MODE_RUN, 16'hFFFF, 16'hFFFF, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 0, 1, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_RUN, 0, 0, 1'b1, completion(0, 1, 1, 0, 1));
        add_row(srtf_pkg::MODE_LOAD, 16'hFFFF, 16'hFFFF, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_RUN, 0, 0, 1'b1, completion(0, 131070, 65535, 0, 1));
        // full table: ties, preemption, a zero burst in the middle, one load too many
        add_row(srtf_pkg::MODE_LOAD, 0, 10, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 0, 4, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 0, 4, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 2, 1, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 16'hAAAA, 16'h5555, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 16'h5555, 16'hAAAA, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 5, 0, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 100, 16'hFFFF, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 3, 2, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 20, 7, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 20, 7, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 21, 6, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 22, 1, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 1, 3, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 40, 2, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 0, 16'h8000, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 41, 1, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_LOAD, 0, 1, 1'b0, NO_CHECK);
        add_row(srtf_pkg::MODE_RUN, 16'h1234, 0, 1'b0, NO_CHECK);
    endfunction

    // called just after a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input srtf_pkg::t_in item, input logic typed,
                             input srtf_pkg::t_out want);
        start  = 1'b1;
        i_item = item;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        void'(predict_item(item));
        items_counted++;
        if (typed) expected_completions.push_back(want);
        else foreach (predicted[k]) expected_completions.push_back(predicted[k]);
        if (item.mode == srtf_pkg::MODE_RUN) runs_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!calm && items_counted < ITEMS_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 16));
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (expected_completions.size() != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    // one job set followed by a run; mostly small sets with tight arrivals
    task automatic random_batch();
        int choice;
        int njobs;
        int arr_span;
        int bur_span;
        srtf_pkg::t_in item;
        choice = $urandom_range(0, 99);
        if (choice < 10) njobs = 0;
        else if (choice < 20) njobs = $urandom_range(TABLE_CAP, TABLE_CAP + 3);
        else njobs = $urandom_range(1, 8);
        choice   = $urandom_range(0, 9);
        arr_span = (choice < 4) ? 7 : (choice < 7) ? 63 : (choice < 9) ? 1023 : 65535;
        choice   = $urandom_range(0, 9);
        bur_span = (choice < 5) ? 15 : (choice < 8) ? 255 : 65535;
        for (int j = 0; j < njobs; j++) begin
            item.mode         = srtf_pkg::MODE_LOAD;
            item.arrival_time = TW'($urandom_range(0, arr_span));
            item.burst_length = ($urandom_range(0, 19) == 0) ? '0 :
                                TW'($urandom_range(1, bur_span));
            maybe_idle();
            send_item(item, 1'b0, NO_CHECK);
        end
        item.mode         = srtf_pkg::MODE_RUN;
        item.arrival_time = TW'($urandom);
        item.burst_length = TW'($urandom);
        maybe_idle();
        send_item(item, 1'b0, NO_CHECK);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_completions.size() == 0) begin
                report_mismatch($sformatf("completion of job %0d with none pending",
                                          o_result.job_index));
            end else begin
                oldest = expected_completions.pop_front();
                completions_checked++;
                if (o_result.job_index !== oldest.job_index)
                    report_mismatch($sformatf("job_index got %0d want %0d",
                                              o_result.job_index, oldest.job_index));
                if (o_result.finish_time !== oldest.finish_time)
                    report_mismatch($sformatf("finish_time got %0d want %0d",
                                              o_result.finish_time, oldest.finish_time));
                if (o_result.turnaround !== oldest.turnaround)
                    report_mismatch($sformatf("turnaround got %0d want %0d",
                                              o_result.turnaround, oldest.turnaround));
                if (o_result.waiting !== oldest.waiting)
                    report_mismatch($sformatf("waiting got %0d want %0d",
                                              o_result.waiting, oldest.waiting));
                if (o_result.last_result !== oldest.last_result)
                    report_mismatch($sformatf("last_result got %0b want %0b",
                                              o_result.last_result, oldest.last_result));
            end
        end
    end

    // counts cycles with no transaction and no completion
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without activity", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        start               = 1'b0;
        i_item              = '0;
        job_count           = 0;
        mismatches          = 0;
        items_counted       = 0;
        runs_sent           = 0;
        completions_checked = 0;
        calm                = 1'b0;
        build_directed();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        wait_drained();

        while (items_counted < ITEMS_TARGET) begin
            calm = ($urandom_range(0, 9) < 3);
            random_batch();
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions in %0d runs, %0d completions compared field by field",
                 items_counted, runs_sent, completions_checked);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/srtf_pkg.sv
sv/srtf_job_store.sv
sv/srtf_schedule_simulator_unit.sv
sim/srtf_schedule_simulator_unit_test.sv
